>>> src/axdr_pkg.sv
package axdr_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_response;
  } in_item_t;

  typedef struct packed {
    logic [7:0] outer_index;
    logic [7:0] row_index;
    logic [7:0] field_index;
    logic [7:0] type_code;
    logic [7:0] field_length;
    logic [7:0] byte_index;
    logic [7:0] value_byte;
    logic       field_end;
    logic [2:0] status;
  } out_item_t;

  localparam logic [7:0] HEADER_LENGTH_RESET = 8'd16;

  // Parser phases
  localparam logic [3:0] PH_HEADER       = 4'd0;
  localparam logic [3:0] PH_TOP_COUNT    = 4'd1;
  localparam logic [3:0] PH_ELEM_TAG     = 4'd2;
  localparam logic [3:0] PH_ARR_TAG      = 4'd3;
  localparam logic [3:0] PH_ARR_COUNT    = 4'd4;
  localparam logic [3:0] PH_STRUCT_TAG   = 4'd5;
  localparam logic [3:0] PH_STRUCT_COUNT = 4'd6;
  localparam logic [3:0] PH_FIELD_TYPE   = 4'd7;
  localparam logic [3:0] PH_FIELD_LEN    = 4'd8;
  localparam logic [3:0] PH_VALUE        = 4'd9;
  localparam logic [3:0] PH_IGNORE       = 4'd10;

  // Result status codes
  localparam logic [2:0] ST_VALUE      = 3'd0;
  localparam logic [2:0] ST_EMPTY_RESP = 3'd1;
  localparam logic [2:0] ST_BAD_TOP    = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
  localparam logic [2:0] ST_EMPTY_FLD  = 3'd4;

  // Tags
  localparam logic [7:0] TAG_NULL       = 8'd0;
  localparam logic [7:0] TAG_ARRAY      = 8'd1;
  localparam logic [7:0] TAG_STRUCTURE  = 8'd2;
  localparam logic [7:0] TAG_BIT_STRING = 8'd4;
  localparam logic [7:0] TAG_OCTET_STR  = 8'd9;

  // Kinds of field type
  localparam logic [1:0] KIND_FIXED   = 2'd0;
  localparam logic [1:0] KIND_LEN     = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] length;
  } type_info_t;

  function automatic type_info_t type_info(input logic [7:0] code);
    type_info_t ti;
    ti.kind   = KIND_FIXED;
    ti.length = 8'd0;
    case (code)
      8'd0:                      ti.length = 8'd0;
      8'd3, 8'd15, 8'd17, 8'd22: ti.length = 8'd1;
      8'd16, 8'd18:              ti.length = 8'd2;
      8'd5, 8'd6, 8'd23:         ti.length = 8'd4;
      8'd20, 8'd21, 8'd24:       ti.length = 8'd8;
      8'd4, 8'd9:                ti.kind   = KIND_LEN;
      default:                   ti.kind   = KIND_UNKNOWN;
    endcase
    return ti;
  endfunction

endpackage

>>> src/axdr_in_reg.sv
module axdr_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  axdr_pkg::in_item_t in_data,
  input  logic               step,
  output logic               held_valid,
  output axdr_pkg::in_item_t held_data
);
  import axdr_pkg::*;

  // The held byte leaves whenever the parser steps, so a new one can enter.
  assign in_stall = held_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_data <= in_data;
    end
  end

endmodule

>>> src/axdr_fsm.sv
module axdr_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  axdr_pkg::in_item_t  item,
  input  logic [7:0]          header_length,
  output logic                res_valid,
  output axdr_pkg::out_item_t res
);
  import axdr_pkg::*;

  logic [3:0] phase, phase_next;
  logic [7:0] position_count, position_count_next;
  logic       nested_flag, nested_flag_next;
  logic [7:0] outer_count, outer_count_next;
  logic [7:0] outer_position, outer_position_next;
  logic [7:0] row_count, row_count_next;
  logic [7:0] row_position, row_position_next;
  logic [7:0] field_count, field_count_next;
  logic [7:0] field_position, field_position_next;
  logic [7:0] current_type, current_type_next;
  logic [7:0] current_length, current_length_next;
  logic [7:0] bytes_done, bytes_done_next;

  type_info_t ti;
  logic [8:0] bits_rounded;
  logic [7:0] b;

  assign b            = item.data_byte;
  assign ti           = type_info(b);
  assign bits_rounded = {1'b0, b} + 9'd7;

  always_comb begin
    logic       idx_en;
    logic       end_field, end_row, end_arr;
    logic       start_val;
    logic [7:0] start_len;

    idx_en    = 1'b0;
    end_field = 1'b0;
    end_row   = 1'b0;
    end_arr   = 1'b0;
    start_val = 1'b0;
    start_len = 8'd0;

    res_valid = 1'b0;
    res       = '0;

    phase_next          = phase;
    position_count_next = position_count;
    nested_flag_next    = nested_flag;
    outer_count_next    = outer_count;
    outer_position_next = outer_position;
    row_count_next      = row_count;
    row_position_next   = row_position;
    field_count_next    = field_count;
    field_position_next = field_position;
    current_type_next   = current_type;
    current_length_next = current_length;
    bytes_done_next     = bytes_done;

    case (phase)
      PH_HEADER: begin
        if (position_count != header_length) begin
          position_count_next = position_count + 8'd1;
        end else if (b == TAG_NULL) begin
          res_valid   = 1'b1;
          res.status  = ST_EMPTY_RESP;
          phase_next  = PH_IGNORE;
        end else if (b == TAG_ARRAY) begin
          phase_next = PH_TOP_COUNT;
        end else begin
          res_valid  = 1'b1;
          res.status = ST_BAD_TOP;
          phase_next = PH_IGNORE;
        end
      end
      PH_TOP_COUNT: begin
        if (b == 8'd0) begin
          res_valid  = 1'b1;
          res.status = ST_EMPTY_RESP;
          phase_next = PH_IGNORE;
        end else begin
          outer_count_next = b;
          phase_next       = PH_ELEM_TAG;
        end
      end
      PH_ELEM_TAG: begin
        if (b == TAG_STRUCTURE) begin
          nested_flag_next    = 1'b0;
          row_count_next      = outer_count;
          outer_count_next    = 8'd1;
          outer_position_next = 8'd0;
          row_position_next   = 8'd0;
          phase_next          = PH_STRUCT_COUNT;
        end else if (b == TAG_ARRAY) begin
          nested_flag_next    = 1'b1;
          outer_position_next = 8'd0;
          phase_next          = PH_ARR_COUNT;
        end else begin
          res_valid     = 1'b1;
          res.status    = ST_BAD_TYPE;
          res.type_code = b;
          phase_next    = PH_IGNORE;
        end
      end
      PH_ARR_TAG: begin
        phase_next = PH_ARR_COUNT;
      end
      PH_ARR_COUNT: begin
        row_count_next    = b;
        row_position_next = 8'd0;
        if (b == 8'd0) begin
          end_arr = 1'b1;
        end else begin
          phase_next = PH_STRUCT_TAG;
        end
      end
      PH_STRUCT_TAG: begin
        phase_next = PH_STRUCT_COUNT;
      end
      PH_STRUCT_COUNT: begin
        field_count_next    = b;
        field_position_next = 8'd0;
        if (b == 8'd0) begin
          end_row = 1'b1;
        end else begin
          phase_next = PH_FIELD_TYPE;
        end
      end
      PH_FIELD_TYPE: begin
        current_type_next = b;
        case (ti.kind)
          KIND_FIXED: begin
            start_val = 1'b1;
            start_len = ti.length;
          end
          KIND_LEN: begin
            phase_next = PH_FIELD_LEN;
          end
          default: begin
            res_valid     = 1'b1;
            idx_en        = 1'b1;
            res.status    = ST_BAD_TYPE;
            res.type_code = b;
            res.field_end = 1'b1;
            phase_next    = PH_IGNORE;
          end
        endcase
      end
      PH_FIELD_LEN: begin
        start_val = 1'b1;
        // Bit-string lengths are given in bits and rounded up to whole bytes.
        if (current_type == TAG_BIT_STRING) begin
          start_len = {2'd0, bits_rounded[8:3]};
        end else begin
          start_len = b;
        end
      end
      PH_VALUE: begin
        res_valid        = 1'b1;
        idx_en           = 1'b1;
        res.status       = ST_VALUE;
        res.type_code    = current_type;
        res.field_length = current_length;
        res.byte_index   = bytes_done;
        res.value_byte   = b;
        res.field_end    = (bytes_done + 8'd1 == current_length);
        bytes_done_next  = bytes_done + 8'd1;
        end_field        = res.field_end;
      end
      default: begin
      end
    endcase

    if (start_val) begin
      bytes_done_next     = 8'd0;
      current_length_next = start_len;
      if (start_len == 8'd0) begin
        res_valid     = 1'b1;
        idx_en        = 1'b1;
        res.status    = ST_EMPTY_FLD;
        res.type_code = current_type_next;
        res.field_end = 1'b1;
        end_field     = 1'b1;
      end else begin
        phase_next = PH_VALUE;
      end
    end

    if (idx_en) begin
      res.outer_index = nested_flag ? outer_position : 8'd0;
      res.row_index   = row_position;
      res.field_index = field_position;
    end

    // Closing a field may close its row, and closing a row may close its array.
    if (end_field) begin
      field_position_next = field_position_next + 8'd1;
      if (field_position_next == field_count_next) begin
        end_row = 1'b1;
      end else begin
        phase_next = PH_FIELD_TYPE;
      end
    end
    if (end_row) begin
      row_position_next = row_position_next + 8'd1;
      if (row_position_next == row_count_next) begin
        end_arr = 1'b1;
      end else begin
        phase_next = PH_STRUCT_TAG;
      end
    end
    if (end_arr) begin
      if (nested_flag_next) begin
        outer_position_next = outer_position_next + 8'd1;
        phase_next = (outer_position_next == outer_count_next) ? PH_IGNORE : PH_ARR_TAG;
      end else begin
        phase_next = PH_IGNORE;
      end
    end

    if (item.end_of_response) begin
      phase_next          = PH_HEADER;
      position_count_next = 8'd0;
      nested_flag_next    = 1'b0;
      outer_count_next    = 8'd0;
      outer_position_next = 8'd0;
      row_count_next      = 8'd0;
      row_position_next   = 8'd0;
      field_count_next    = 8'd0;
      field_position_next = 8'd0;
      current_type_next   = 8'd0;
      current_length_next = 8'd0;
      bytes_done_next     = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      position_count <= 8'd0;
      nested_flag    <= 1'b0;
      outer_count    <= 8'd0;
      outer_position <= 8'd0;
      row_count      <= 8'd0;
      row_position   <= 8'd0;
      field_count    <= 8'd0;
      field_position <= 8'd0;
      current_type   <= 8'd0;
      current_length <= 8'd0;
      bytes_done     <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      position_count <= position_count_next;
      nested_flag    <= nested_flag_next;
      outer_count    <= outer_count_next;
      outer_position <= outer_position_next;
      row_count      <= row_count_next;
      row_position   <= row_position_next;
      field_count    <= field_count_next;
      field_position <= field_position_next;
      current_type   <= current_type_next;
      current_length <= current_length_next;
      bytes_done     <= bytes_done_next;
    end
  end

  a_eor_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.end_of_response |=> phase == PH_HEADER && position_count == 8'd0)
    else $error("state not cleared after end of response");

  a_ignore_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IGNORE |-> !res_valid)
    else $error("result produced while ignoring bytes");

  a_value_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_VALUE |-> phase == PH_VALUE)
    else $error("value byte reported outside the value phase");

  a_value_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> bytes_done < current_length)
    else $error("value byte count passed the field length");

endmodule

>>> src/axdr_out_reg.sv
module axdr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  axdr_pkg::out_item_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output axdr_pkg::out_item_t out_data
);
  import axdr_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> src/axdr_record_table_parser.sv
// Each byte is held in the input register; when the parser steps, its result, if any, is
// loaded into the result register, and out_valid rises as that register is loaded.
// Throughput: one byte per cycle; the parser steps whenever the result register is
// free or being emptied in the same cycle, and every held byte waits on it.
// Reset (rst, synchronous) clears the parser to its header phase, empties both
// registers and sets header_length to 16.
module axdr_record_table_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  axdr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output axdr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import axdr_pkg::*;

  logic       held_valid;
  in_item_t   held_data;
  logic       step;
  logic       free;
  logic       res_valid;
  out_item_t  res;
  logic [7:0] header_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= HEADER_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_length <= cfg_data;
    end
  end

  assign step = held_valid && free;

  axdr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .step       (step),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  axdr_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (held_data),
    .header_length (header_length),
    .res_valid     (res_valid),
    .res           (res)
  );

  axdr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_data (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sim/axdr_record_table_parser_tb.sv
module axdr_record_table_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import axdr_pkg::*;

  // Field type codes with a fixed value length
  localparam logic [7:0] T_BOOLEAN         = 8'd3;
  localparam logic [7:0] T_DOUBLE_LONG     = 8'd5;
  localparam logic [7:0] T_DOUBLE_LONG_UNS = 8'd6;
  localparam logic [7:0] T_INTEGER         = 8'd15;
  localparam logic [7:0] T_LONG            = 8'd16;
  localparam logic [7:0] T_UNSIGNED        = 8'd17;
  localparam logic [7:0] T_LONG_UNS        = 8'd18;
  localparam logic [7:0] T_LONG64          = 8'd20;
  localparam logic [7:0] T_LONG64_UNS      = 8'd21;
  localparam logic [7:0] T_ENUM            = 8'd22;
  localparam logic [7:0] T_FLOAT32         = 8'd23;
  localparam logic [7:0] T_FLOAT64         = 8'd24;
  localparam int         NUM_FIXED_TYPES   = 13;

  localparam int LEN_PREFIXED = -1;
  localparam int LEN_UNKNOWN  = -2;

  localparam int TOTAL_BYTES  = 1450;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  axdr_record_table_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Parser state mirrored by the testbench
  logic [7:0] hdr_len;
  logic [3:0] ph;
  logic [7:0] pos_cnt, outer_cnt, outer_pos, row_cnt, row_pos;
  logic [7:0] fld_cnt, fld_pos, cur_type, cur_len, done_cnt;
  logic       nested;

  out_item_t  field_records[$];
  out_item_t  head_rec;
  logic [7:0] frame[$];

  bit calm = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int parsed_bytes = 0;
  int responses = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int status_seen[8];
  int quiet_cycles = 0;
  int stall_span = 0;

  function automatic int type_length(logic [7:0] t);
    case (t)
      TAG_NULL:                                      return 0;
      T_BOOLEAN, T_INTEGER, T_UNSIGNED, T_ENUM:      return 1;
      T_LONG, T_LONG_UNS:                            return 2;
      T_DOUBLE_LONG, T_DOUBLE_LONG_UNS, T_FLOAT32:   return 4;
      T_LONG64, T_LONG64_UNS, T_FLOAT64:             return 8;
      TAG_BIT_STRING, TAG_OCTET_STR:                 return LEN_PREFIXED;
      default:                                       return LEN_UNKNOWN;
    endcase
  endfunction

  function automatic logic [7:0] fixed_type(int k);
    case (k)
      0:       return T_BOOLEAN;
      1:       return T_DOUBLE_LONG;
      2:       return T_DOUBLE_LONG_UNS;
      3:       return T_INTEGER;
      4:       return T_LONG;
      5:       return T_UNSIGNED;
      6:       return T_LONG_UNS;
      7:       return T_LONG64;
      8:       return T_LONG64_UNS;
      9:       return T_ENUM;
      10:      return T_FLOAT32;
      default: return T_FLOAT64;
    endcase
  endfunction

  function automatic void clear_parser();
    ph = PH_HEADER;
    pos_cnt = 8'd0;
    nested = 1'b0;
    outer_cnt = 8'd0;
    outer_pos = 8'd0;
    row_cnt = 8'd0;
    row_pos = 8'd0;
    fld_cnt = 8'd0;
    fld_pos = 8'd0;
    cur_type = 8'd0;
    cur_len = 8'd0;
    done_cnt = 8'd0;
  endfunction

  function automatic void emit(logic [2:0] st, bit with_idx, logic [7:0] tc, logic [7:0] len,
                               logic [7:0] bidx, logic [7:0] val, logic fend);
    out_item_t r;
    r.outer_index  = (with_idx && nested) ? outer_pos : 8'd0;
    r.row_index    = with_idx ? row_pos : 8'd0;
    r.field_index  = with_idx ? fld_pos : 8'd0;
    r.type_code    = tc;
    r.field_length = len;
    r.byte_index   = bidx;
    r.value_byte   = val;
    r.field_end    = fend;
    r.status       = st;
    field_records.push_back(r);
  endfunction

  function automatic void close_array();
    if (nested) begin
      outer_pos = outer_pos + 8'd1;
      ph = (outer_pos == outer_cnt) ? PH_IGNORE : PH_ARR_TAG;
    end else begin
      ph = PH_IGNORE;
    end
  endfunction

  function automatic void close_row();
    row_pos = row_pos + 8'd1;
    if (row_pos == row_cnt) close_array();
    else ph = PH_STRUCT_TAG;
  endfunction

  function automatic void close_field();
    fld_pos = fld_pos + 8'd1;
    if (fld_pos == fld_cnt) close_row();
    else ph = PH_FIELD_TYPE;
  endfunction

  function automatic void open_value(int len);
    done_cnt = 8'd0;
    cur_len = len[7:0];
    if (len == 0) begin
      emit(ST_EMPTY_FLD, 1'b1, cur_type, 8'd0, 8'd0, 8'd0, 1'b1);
      close_field();
    end else begin
      ph = PH_VALUE;
    end
  endfunction

  // Advances the mirrored parser by one response byte and queues the record it yields.
  function automatic void parse_byte(logic [7:0] b, logic last);
    int n;
    bit fin;
    if (ph != PH_HEADER && ph != PH_IGNORE) parsed_bytes++;
    case (ph)
      PH_HEADER: begin
        if (pos_cnt != hdr_len) begin
          pos_cnt = pos_cnt + 8'd1;
        end else if (b == TAG_NULL) begin
          emit(ST_EMPTY_RESP, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
          ph = PH_IGNORE;
        end else if (b == TAG_ARRAY) begin
          ph = PH_TOP_COUNT;
        end else begin
          emit(ST_BAD_TOP, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
          ph = PH_IGNORE;
        end
      end
      PH_TOP_COUNT: begin
        if (b == 8'd0) begin
          emit(ST_EMPTY_RESP, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
          ph = PH_IGNORE;
        end else begin
          outer_cnt = b;
          ph = PH_ELEM_TAG;
        end
      end
      PH_ELEM_TAG: begin
        if (b == TAG_STRUCTURE) begin
          // A plain table is handled as a single outer array.
          nested = 1'b0;
          row_cnt = outer_cnt;
          outer_cnt = 8'd1;
          outer_pos = 8'd0;
          row_pos = 8'd0;
          ph = PH_STRUCT_COUNT;
        end else if (b == TAG_ARRAY) begin
          nested = 1'b1;
          outer_pos = 8'd0;
          ph = PH_ARR_COUNT;
        end else begin
          emit(ST_BAD_TYPE, 1'b0, b, 8'd0, 8'd0, 8'd0, 1'b0);
          ph = PH_IGNORE;
        end
      end
      PH_ARR_TAG: ph = PH_ARR_COUNT;
      PH_ARR_COUNT: begin
        row_cnt = b;
        row_pos = 8'd0;
        if (b == 8'd0) close_array();
        else ph = PH_STRUCT_TAG;
      end
      PH_STRUCT_TAG: ph = PH_STRUCT_COUNT;
      PH_STRUCT_COUNT: begin
        fld_cnt = b;
        fld_pos = 8'd0;
        if (b == 8'd0) close_row();
        else ph = PH_FIELD_TYPE;
      end
      PH_FIELD_TYPE: begin
        cur_type = b;
        n = type_length(b);
        if (n == LEN_PREFIXED) begin
          ph = PH_FIELD_LEN;
        end else if (n == LEN_UNKNOWN) begin
          emit(ST_BAD_TYPE, 1'b1, b, 8'd0, 8'd0, 8'd0, 1'b1);
          ph = PH_IGNORE;
        end else begin
          open_value(n);
        end
      end
      PH_FIELD_LEN: begin
        n = int'(b);
        // Bit-string lengths are given in bits.
        if (cur_type == TAG_BIT_STRING) open_value((n + 7) / 8);
        else open_value(n);
      end
      PH_VALUE: begin
        fin = (int'(done_cnt) + 1 == int'(cur_len));
        emit(ST_VALUE, 1'b1, cur_type, cur_len, done_cnt, b, fin);
        done_cnt = done_cnt + 8'd1;
        if (fin) close_field();
      end
      default: ;
    endcase
    if (last) clear_parser();
  endfunction

  function automatic int idle_length(bit sender);
    int p;
    p = $urandom_range(0, 99);
    if (sender && p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response construction

  function automatic void start_frame();
    frame.delete();
    repeat (hdr_len) frame.push_back(8'($urandom));
  endfunction

  function automatic void put_field(logic [7:0] t, logic [7:0] len_byte);
    int n;
    n = type_length(t);
    frame.push_back(t);
    if (n == LEN_UNKNOWN) return;
    if (n == LEN_PREFIXED) begin
      frame.push_back(len_byte);
      n = int'(len_byte);
      if (t == TAG_BIT_STRING) n = (n + 7) / 8;
    end
    repeat (n) frame.push_back(8'($urandom));
  endfunction

  function automatic logic [7:0] string_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 8'($urandom_range(0, 8));
    if (p < 95) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  // Tags that the parser skips are occasionally replaced by arbitrary bytes.
  function automatic logic [7:0] skipped_tag(logic [7:0] t);
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return t;
  endfunction

  function automatic void add_struct(bit with_tag);
    int p;
    int fc;
    logic [7:0] t;
    if (with_tag) frame.push_back(skipped_tag(TAG_STRUCTURE));
    fc = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 4);
    frame.push_back(8'(fc));
    repeat (fc) begin
      p = $urandom_range(0, 99);
      if (p < 6) t = TAG_NULL;
      else if (p < 22) t = TAG_OCTET_STR;
      else if (p < 32) t = TAG_BIT_STRING;
      else if (p < 34) t = 8'($urandom);
      else t = fixed_type($urandom_range(0, NUM_FIXED_TYPES - 1));
      put_field(t, string_length());
    end
  endfunction

  function automatic void add_table();
    int outer;
    int rows;
    int o;
    int r;
    frame.push_back(TAG_ARRAY);
    if ($urandom_range(0, 2) == 0) begin
      outer = $urandom_range(1, 3);
      frame.push_back(8'(outer));
      for (o = 0; o < outer; o++) begin
        frame.push_back(o == 0 ? TAG_ARRAY : skipped_tag(TAG_ARRAY));
        rows = $urandom_range(0, 3);
        frame.push_back(8'(rows));
        repeat (rows) add_struct(1'b1);
      end
    end else begin
      rows = $urandom_range(1, 5);
      frame.push_back(8'(rows));
      frame.push_back(TAG_STRUCTURE);
      for (r = 0; r < rows; r++) add_struct(r != 0);
    end
  endfunction

  // Driving

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = calm ? 0 : idle_length(1'b1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.data_byte <= b;
    in_data.end_of_response <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    responses++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (field_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_header(logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hdr_len = v;
    cfg_writes++;
  endtask

  // Tests

  task automatic test_reset_header();
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd2);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd2);
    put_field(T_UNSIGNED, 8'd0);
    put_field(T_LONG_UNS, 8'd0);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    put_field(TAG_NULL, 8'd0);
    send_frame();
  endtask

  task automatic test_top_level_status();
    set_header(8'd0);
    start_frame();
    frame.push_back(TAG_NULL);
    frame.push_back(8'hA5);
    send_frame();
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd0);
    send_frame();
    start_frame();
    frame.push_back(8'hFF);
    send_frame();
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd3);
    frame.push_back(8'h07);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    send_frame();
  endtask

  task automatic test_field_types();
    int k;
    set_header(8'd3);
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd22);
    for (k = 0; k < NUM_FIXED_TYPES; k++) put_field(fixed_type(k), 8'd0);
    put_field(TAG_NULL, 8'd0);
    put_field(TAG_OCTET_STR, 8'd0);
    put_field(TAG_OCTET_STR, 8'd1);
    put_field(TAG_OCTET_STR, 8'd255);
    put_field(TAG_BIT_STRING, 8'd0);
    put_field(TAG_BIT_STRING, 8'd1);
    put_field(TAG_BIT_STRING, 8'd8);
    put_field(TAG_BIT_STRING, 8'd9);
    put_field(TAG_BIT_STRING, 8'd255);
    send_frame();
    // An unknown type stops the parse; the bytes after it are ignored.
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd3);
    put_field(T_ENUM, 8'd0);
    frame.push_back(8'hFF);
    repeat (3) frame.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic test_nested_tables();
    set_header(8'd2);
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd3);
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd2);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd2);
    put_field(T_LONG, 8'd0);
    put_field(TAG_OCTET_STR, 8'd3);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd0);
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd0);
    frame.push_back(8'h5A);
    frame.push_back(8'd1);
    frame.push_back(8'hC3);
    frame.push_back(8'd1);
    put_field(T_DOUBLE_LONG, 8'd0);
    repeat (5) frame.push_back(8'($urandom));
    send_frame();
    // Response cut short in the middle of a value.
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    put_field(T_LONG64, 8'd0);
    repeat (4) void'(frame.pop_back());
    send_frame();
    // Response that ends inside the header.
    frame.delete();
    frame.push_back(TAG_ARRAY);
    send_frame();
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    put_field(T_FLOAT32, 8'd0);
    send_frame();
  endtask

  task automatic test_long_table();
    set_header(8'd1);
    calm = 1'b1;
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd3);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd255);
    repeat (255) put_field(TAG_NULL, 8'd0);
    repeat (1) begin
      frame.push_back(TAG_STRUCTURE);
      frame.push_back(8'd1);
      put_field(TAG_NULL, 8'd0);
    end
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    put_field(T_FLOAT64, 8'd0);
    send_frame();
    calm = 1'b0;
  endtask

  task automatic test_header_extremes();
    set_header(8'd255);
    start_frame();
    frame.push_back(TAG_ARRAY);
    frame.push_back(8'd1);
    frame.push_back(TAG_STRUCTURE);
    frame.push_back(8'd1);
    put_field(T_LONG64_UNS, 8'd0);
    send_frame();
    start_frame();
    frame.push_back(TAG_NULL);
    send_frame();
  endtask

  task automatic random_response();
    int p;
    int cut;
    start_frame();
    p = $urandom_range(0, 99);
    if (p < 75) begin
      add_table();
    end else if (p < 79) begin
      frame.push_back(TAG_NULL);
    end else if (p < 83) begin
      frame.push_back(TAG_ARRAY);
      frame.push_back(8'd0);
    end else if (p < 87) begin
      frame.push_back(8'($urandom));
    end else if (p < 92) begin
      frame.push_back(TAG_ARRAY);
      frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
    end
    p = $urandom_range(0, 99);
    if (p < 10) begin
      frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
    end else if (p < 18 && frame.size() > 1) begin
      cut = $urandom_range(1, frame.size() - 1);
      while (frame.size() > cut) void'(frame.pop_back());
    end
    send_frame();
  endtask

  task automatic test_random_responses();
    int p;
    logic [7:0] h;
    while (bytes_sent < TOTAL_BYTES) begin
      p = $urandom_range(0, 9);
      if (p < 3) h = 8'd0;
      else if (p < 5) h = HEADER_LENGTH_RESET;
      else h = 8'($urandom_range(1, 12));
      set_header(h);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) random_response();
    end
    calm = 1'b0;
  endtask

  // Result side

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_span <= 0;
    end else if (stall_span > 1) begin
      stall_span <= stall_span - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      stall_span <= idle_length(1'b0);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (field_records.size() == 0) begin
        errors++;
        $display("%0t: result with none outstanding, expected nothing, actual %h",
                 $time, out_data);
      end else begin
        head_rec = field_records.pop_front();
        check_field("outer_index", head_rec.outer_index, out_data.outer_index);
        check_field("row_index", head_rec.row_index, out_data.row_index);
        check_field("field_index", head_rec.field_index, out_data.field_index);
        check_field("type_code", head_rec.type_code, out_data.type_code);
        check_field("field_length", head_rec.field_length, out_data.field_length);
        check_field("byte_index", head_rec.byte_index, out_data.byte_index);
        check_field("value_byte", head_rec.value_byte, out_data.value_byte);
        check_field("field_end", {7'd0, head_rec.field_end}, {7'd0, out_data.field_end});
        check_field("status", {5'd0, head_rec.status}, {5'd0, out_data.status});
        status_seen[head_rec.status]++;
        results_seen++;
      end
    end
  end

  // Ends the run if no transaction completes on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL axdr_record_table_parser");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    hdr_len = HEADER_LENGTH_RESET;
    clear_parser();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_header();
    test_top_level_status();
    test_field_types();
    test_nested_tables();
    test_long_table();
    test_header_extremes();
    test_random_responses();
    wait_idle();
    $display("Sent %0d responses (%0d bytes, %0d past the header) over %0d header settings.",
             responses, bytes_sent, parsed_bytes, cfg_writes + 1);
    $display("Checked %0d results: %0d values, %0d empty, %0d bad tag, %0d bad type,",
             results_seen, status_seen[ST_VALUE], status_seen[ST_EMPTY_RESP],
             status_seen[ST_BAD_TOP], status_seen[ST_BAD_TYPE]);
    $display("and %0d empty field.", status_seen[ST_EMPTY_FLD]);
    if (errors == 0) begin
      $display("PASS axdr_record_table_parser");
    end else begin
      $display("FAIL axdr_record_table_parser");
    end
    $finish;
  end

endmodule
